/* hdl/ffba_pkg.sv */
`timescale 1ns / 1ps

package ffba_pkg;

  // Operation codes carried in the input word.
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NONE  = 2'd3
  } ffba_op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2,
    ST_RSVD    = 2'd3
  } ffba_status_t;

  // Configuration register indexes.
  localparam logic CFG_BASE_ADDRESS = 1'b0;
  localparam logic CFG_POOL_SIZE    = 1'b1;

  localparam logic [15:0] RESET_POOL_SIZE = 16'd3096;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] request_size;
    logic [31:0] free_address;
  } ffba_in_t;

  typedef struct packed {
    logic [31:0] data_address;
    logic [1:0]  status;
  } ffba_out_t;

  // One table entry. Block sizes never exceed the pool size, so 16 bits hold them.
  typedef struct packed {
    logic        used;
    logic [15:0] size;
  } ffba_entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SPL_RD,
    S_SPL_WR,
    S_ALLOC_WR1,
    S_ALLOC_WR0,
    S_RM_RD,
    S_RM_CHK,
    S_LM_RD,
    S_LM_CHK,
    S_MERGE_WR,
    S_CMP_RD,
    S_CMP_WR,
    S_DONE
  } ffba_state_t;

endpackage

/* hdl/ffba_ram.sv */
`timescale 1ns / 1ps

module ffba_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/first_fit_block_allocator.sv */
`timescale 1ns / 1ps

// Channel | Direction | Handshake          | Word
// in_     | input     | in_valid/in_stall  | ffba_in_t: operation, request_size, free_address
// out_    | output    | out_valid/out_stall| ffba_out_t: data_address, status
// cfg_    | input     | cfg_we             | cfg_index selects base_address or pool_size
//
// An operation reads and checks each table entry visited through the single block
// table RAM port pair, and reads and writes each entry moved by a split or compaction.
// After reset the S_INIT state rebuilds entry zero before in_stall falls. A finished
// word waits in the output register, and the next word is taken meanwhile; the
// sequencer holds only when a second result is ready.
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ffba_pkg::ffba_in_t  in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output ffba_pkg::ffba_out_t out_word,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data
);

  import ffba_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);
  localparam logic [15:0] HDR16 = 16'(HEADER_BYTES);
  localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);

  ffba_state_t state_r, state_nxt;
  logic [31:0] base_r;
  logic [15:0] pool_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] aux_r, aux_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [31:0] off_r, off_nxt;
  logic [15:0] acc_r, acc_nxt;
  ffba_in_t req_r, req_nxt;
  logic is_op_r, is_op_nxt;
  ffba_out_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  ffba_out_t out_r, out_nxt;

  logic ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  ffba_entry_t ram_wdata, ram_rdata;
  logic [16:0] rem;
  logic [31:0] data_addr;

  ffba_ram #(
    .WIDTH($bits(ffba_entry_t)),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // Spare bytes of the entry under test, and the data address of that entry.
  assign rem       = {1'b0, ram_rdata.size} - {1'b0, req_r.request_size};
  assign data_addr = base_r + off_r + HDR32;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      pool_r <= RESET_POOL_SIZE;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BASE_ADDRESS) begin
        base_r <= cfg_data;
      end else begin
        pool_r <= cfg_data[15:0];
      end
    end
  end

  // Sequencer and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= CNT_W'(1);
      is_op_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      is_op_r     <= is_op_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r <= idx_nxt;
    aux_r <= aux_nxt;
    lo_r  <= lo_nxt;
    off_r <= off_nxt;
    acc_r <= acc_nxt;
    req_r <= req_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    aux_nxt       = aux_r;
    lo_nxt        = lo_r;
    off_nxt       = off_r;
    acc_nxt       = acc_r;
    req_nxt       = req_r;
    is_op_nxt     = is_op_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    // The output register empties when the consumer takes the word.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_word;
          idx_nxt = '0;
          off_nxt = '0;
          res_nxt = '{data_address: '0, status: ST_OK};
          unique case (ffba_op_t'(in_word.operation))
            OP_ALLOC, OP_FREE: state_nxt = S_SCAN_RD;
            OP_INIT: begin
              is_op_nxt = 1'b1;
              state_nxt = S_INIT;
            end
            OP_NONE: state_nxt = S_DONE;
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // Rebuild the table as one free block.
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '{used: 1'b0, size: pool_r};
        count_nxt = CNT_W'(1);
        is_op_nxt = 1'b0;
        state_nxt = is_op_r ? S_DONE : S_IDLE;
      end

      // Walk the table in address order.
      S_SCAN_RD: begin
        if (idx_r == count_r) begin
          res_nxt.status = (ffba_op_t'(req_r.operation) == OP_ALLOC) ? ST_NOFIT : ST_BADFREE;
          state_nxt = S_DONE;
        end else begin
          ram_raddr = idx_r[IDX_W-1:0];
          state_nxt = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        if (ffba_op_t'(req_r.operation) == OP_ALLOC) begin
          if (!ram_rdata.used && !rem[16]) begin
            acc_nxt = ram_rdata.size;
            res_nxt.data_address = data_addr;
            if (rem[15:0] > HDR16 && count_r < MAX_CNT) begin
              aux_nxt   = count_r;
              state_nxt = S_SPL_RD;
            end else begin
              state_nxt = S_ALLOC_WR0;
            end
          end else begin
            off_nxt   = off_r + HDR32 + 32'(ram_rdata.size);
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_SCAN_RD;
          end
        end else begin
          if (ram_rdata.used && data_addr == req_r.free_address) begin
            acc_nxt   = ram_rdata.size;
            lo_nxt    = idx_r;
            state_nxt = S_RM_RD;
          end else begin
            off_nxt   = off_r + HDR32 + 32'(ram_rdata.size);
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_SCAN_RD;
          end
        end
      end

      // Open a slot behind the chosen entry, moving the tail up by one.
      S_SPL_RD: begin
        if (aux_r > idx_r + 1'b1) begin
          ram_raddr = IDX_W'(aux_r - 1'b1);
          state_nxt = S_SPL_WR;
        end else begin
          state_nxt = S_ALLOC_WR1;
        end
      end

      S_SPL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = aux_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        aux_nxt   = aux_r - 1'b1;
        state_nxt = S_SPL_RD;
      end

      // Free remainder of the split.
      S_ALLOC_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(idx_r + 1'b1);
        ram_wdata = '{used: 1'b0, size: acc_r - req_r.request_size - HDR16};
        count_nxt = count_r + 1'b1;
        acc_nxt   = req_r.request_size;
        state_nxt = S_ALLOC_WR0;
      end

      S_ALLOC_WR0: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[IDX_W-1:0];
        ram_wdata = '{used: 1'b1, size: acc_r};
        state_nxt = S_DONE;
      end

      // Gather free neighbors to the right; idx_r marks the last merged entry.
      S_RM_RD: begin
        if (idx_r + 1'b1 < count_r) begin
          ram_raddr = IDX_W'(idx_r + 1'b1);
          state_nxt = S_RM_CHK;
        end else begin
          state_nxt = S_LM_RD;
        end
      end

      S_RM_CHK: begin
        if (!ram_rdata.used) begin
          acc_nxt   = acc_r + ram_rdata.size + HDR16;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RM_RD;
        end else begin
          state_nxt = S_LM_RD;
        end
      end

      // Gather free neighbors to the left; lo_r marks the first merged entry.
      S_LM_RD: begin
        if (lo_r != '0) begin
          ram_raddr = IDX_W'(lo_r - 1'b1);
          state_nxt = S_LM_CHK;
        end else begin
          state_nxt = S_MERGE_WR;
        end
      end

      S_LM_CHK: begin
        if (!ram_rdata.used) begin
          acc_nxt   = acc_r + ram_rdata.size + HDR16;
          lo_nxt    = lo_r - 1'b1;
          state_nxt = S_LM_RD;
        end else begin
          state_nxt = S_MERGE_WR;
        end
      end

      // Write the merged block, then close the gap behind it.
      S_MERGE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r[IDX_W-1:0];
        ram_wdata = '{used: 1'b0, size: acc_r};
        aux_nxt   = idx_r + 1'b1;
        count_nxt = count_r - (idx_r - lo_r);
        lo_nxt    = lo_r + 1'b1;
        idx_nxt   = count_r;
        state_nxt = S_CMP_RD;
      end

      // Compaction: aux_r is the source, lo_r the destination, idx_r the old count.
      S_CMP_RD: begin
        if (aux_r < idx_r) begin
          ram_raddr = aux_r[IDX_W-1:0];
          state_nxt = S_CMP_WR;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_CMP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        aux_nxt   = aux_r + 1'b1;
        lo_nxt    = lo_r + 1'b1;
        state_nxt = S_CMP_RD;
      end

      // Hand the word over once the output register is free.
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
